// ----- rtl/ufe_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the disjoint-set engine.
// No dependencies; used by ufe_ram and union_find_engine_top.
package ufe_pkg;

    localparam int unsigned NODES    = 1024;
    localparam int unsigned IDX_W    = $clog2(NODES);
    localparam int unsigned NODE_W   = 10;
    localparam int unsigned RANK_W   = 4;
    localparam int unsigned RANK_MAX = 15;

    localparam logic OP_UNION = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [RANK_W-1:0] t_rank;

    typedef struct packed {
        t_rank rank;
        t_idx  parent;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_entry data;
    } t_wr_req;

    function automatic t_idx to_idx(input logic [NODE_W-1:0] node);
        return IDX_W'(node);
    endfunction

endpackage

// ----- rtl/union_find_engine_top.sv -----
`timescale 1ns / 1ps
// Top level of the disjoint-set engine: sequencer, root compare and result register.
// Depends on ufe_pkg and ufe_ram.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------
//  input   | i_in_valid / o_in_ready | i_op, i_node_a, i_node_b
//  output  | o_out_valid / i_out_ready | o_answer
//
// After reset the node table is cleared one entry per cycle, with o_in_ready low.
// A transaction follows the links from a to its root and then from b to its root; each link
// costs one find read and one compression write on the table, and a merge that raises the new
// root's rank adds a rank write. Union by rank keeps the paths to the roots short.
// The result waits in an output register, so a new transaction is taken while it is stalled.
module union_find_engine_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_op,
    input  logic [ufe_pkg::NODE_W-1:0] i_node_a,
    input  logic [ufe_pkg::NODE_W-1:0] i_node_b,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_answer
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_COMP,
        S_JOIN,
        S_RANK,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    ufe_pkg::t_idx   r_cur, n_cur;
    ufe_pkg::t_idx   r_start, n_start;
    ufe_pkg::t_idx   r_root, n_root;
    ufe_pkg::t_idx   r_b, n_b;
    ufe_pkg::t_idx   r_ra, n_ra;
    ufe_pkg::t_idx   r_rb, n_rb;
    ufe_pkg::t_rank  r_ka, n_ka;
    ufe_pkg::t_rank  r_kb, n_kb;
    logic            r_which, n_which;
    logic            r_op, n_op;
    logic            r_ans, n_ans;
    logic            r_out_valid, n_out_valid;
    logic            r_out_answer, n_out_answer;

    logic             rd_en;
    ufe_pkg::t_idx    rd_addr;
    ufe_pkg::t_wr_req wr;
    ufe_pkg::t_entry  rd_data;
    logic             phase_end;
    logic             in_range;
    ufe_pkg::t_idx    child, top;
    ufe_pkg::t_rank   kchild, ktop;
    logic [ufe_pkg::RANK_W:0] rank_inc;
    ufe_pkg::t_rank   new_rank;

    ufe_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_rd_data (rd_data)
    );

    assign in_range = (32'(i_node_a) < ufe_pkg::NODES) && (32'(i_node_b) < ufe_pkg::NODES);

    always_comb begin
        if (r_ka > r_kb) begin
            child  = r_rb;
            top    = r_ra;
            kchild = r_kb;
            ktop   = r_ka;
        end else begin
            child  = r_ra;
            top    = r_rb;
            kchild = r_ka;
            ktop   = r_kb;
        end
        rank_inc = {1'b0, kchild} + 1'b1;
        if (rank_inc > (ufe_pkg::RANK_W + 1)'(ufe_pkg::RANK_MAX)) begin
            new_rank = ufe_pkg::RANK_W'(ufe_pkg::RANK_MAX);
        end else begin
            new_rank = rank_inc[ufe_pkg::RANK_W-1:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_start      = r_start;
        n_root       = r_root;
        n_b          = r_b;
        n_ra         = r_ra;
        n_rb         = r_rb;
        n_ka         = r_ka;
        n_kb         = r_kb;
        n_which      = r_which;
        n_op         = r_op;
        n_ans        = r_ans;
        n_out_valid  = r_out_valid;
        n_out_answer = r_out_answer;
        rd_en        = 1'b0;
        rd_addr      = r_cur;
        wr           = '0;
        phase_end    = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                wr.en          = 1'b1;
                wr.addr        = r_cur;
                wr.data.parent = r_cur;
                wr.data.rank   = ufe_pkg::RANK_W'(1);
                n_cur          = r_cur + 1'b1;
                if (r_cur == ufe_pkg::IDX_W'(ufe_pkg::NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_op;
                    n_b  = ufe_pkg::to_idx(i_node_b);
                    if (!in_range) begin
                        n_ans   = (i_op == ufe_pkg::OP_QUERY) && (i_node_a == i_node_b);
                        n_state = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = ufe_pkg::to_idx(i_node_a);
                        n_cur   = ufe_pkg::to_idx(i_node_a);
                        n_start = ufe_pkg::to_idx(i_node_a);
                        n_which = 1'b0;
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (rd_data.parent == r_cur) begin
                    n_root = r_cur;
                    if (!r_which) begin
                        n_ra = r_cur;
                        n_ka = rd_data.rank;
                    end else begin
                        n_rb = r_cur;
                        n_kb = rd_data.rank;
                    end
                    if (r_start != r_cur) begin
                        rd_en   = 1'b1;
                        rd_addr = r_start;
                        n_cur   = r_start;
                        n_state = S_COMP;
                    end else begin
                        phase_end = 1'b1;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = rd_data.parent;
                    n_cur   = rd_data.parent;
                end
            end
            S_COMP: begin
                wr.en          = 1'b1;
                wr.addr        = r_cur;
                wr.data.parent = r_root;
                wr.data.rank   = rd_data.rank;
                if (rd_data.parent == r_root) begin
                    phase_end = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = rd_data.parent;
                    n_cur   = rd_data.parent;
                end
            end
            S_JOIN: begin
                if (r_op == ufe_pkg::OP_QUERY) begin
                    n_ans   = (r_ra == r_rb);
                    n_state = S_DONE;
                end else if (r_ra == r_rb) begin
                    n_ans   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_ans          = 1'b1;
                    wr.en          = 1'b1;
                    wr.addr        = child;
                    wr.data.parent = top;
                    wr.data.rank   = kchild;
                    if (new_rank > ktop) begin
                        n_root  = top;
                        n_ka    = new_rank;
                        n_state = S_RANK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RANK: begin
                wr.en          = 1'b1;
                wr.addr        = r_root;
                wr.data.parent = r_root;
                wr.data.rank   = r_ka;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_answer = r_ans;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (phase_end) begin
            if (!r_which) begin
                rd_en   = 1'b1;
                rd_addr = r_b;
                n_cur   = r_b;
                n_start = r_b;
                n_which = 1'b1;
                n_state = S_FIND;
            end else begin
                n_state = S_JOIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
        r_start      <= n_start;
        r_root       <= n_root;
        r_b          <= n_b;
        r_ra         <= n_ra;
        r_rb         <= n_rb;
        r_ka         <= n_ka;
        r_kb         <= n_kb;
        r_which      <= n_which;
        r_op         <= n_op;
        r_ans        <= n_ans;
        r_out_answer <= n_out_answer;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_answer    = r_out_answer;

endmodule

// ----- rtl/ufe_ram.sv -----
`timescale 1ns / 1ps
// Node table holding parent link and rank for every node.
// One write port and one registered read port; depends on ufe_pkg.
module ufe_ram (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  ufe_pkg::t_idx   i_rd_addr,
    input  ufe_pkg::t_wr_req i_wr,
    output ufe_pkg::t_entry o_rd_data
);

    ufe_pkg::t_entry r_mem [0:ufe_pkg::NODES-1];
    ufe_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
